[design/lphs_pkg.sv]
// Shared types and constants for the linear-probing hash set.
`timescale 1ns / 1ps

package lphs_pkg;

    // Multiplier for the Fibonacci hash and the bit where the home slot starts.
    localparam logic [63:0] FIB_MUL    = 64'h9E37_79B9_7F4A_7C15;
    localparam int          HASH_SHIFT = 24;

    // Width of the reported entry count.
    localparam int ENTRY_W = 10;

    // Request modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic               inserted;
        logic               full_res;
        logic [ENTRY_W-1:0] entry_count;
    } rsp_t;

endpackage

[design/linear_probe_hash_set.sv]
// Fixed-capacity hash set of 64-bit keys with Fibonacci hashing and linear probing.
// A nonzero key is hashed, its home slot is read, and the walk then probes one slot per
// synchronous memory read until it meets the key, meets an empty slot or has probed every
// slot; key zero is settled in the hash state without touching the table. A new request
// is taken only in the idle state, once the previous result is in the output register.
// Reset: asynchronous, active low; afterwards the slot memory is cleared one slot per
// cycle through all SLOTS slots, during which no request transaction is accepted.
`timescale 1ns / 1ps

module linear_probe_hash_set #(
    parameter int SLOTS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lphs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lphs_pkg::rsp_t rsp
);

    // Index width of the table. The count of stored keys never reaches SLOTS,
    // so the same width holds it.
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W;
    // A new key is refused once (count + 1) * 4 >= SLOTS * 3, that is, once the
    // count has reached three quarters of SLOTS minus one.
    localparam int LIMIT = (SLOTS / 4) * 3 - 1;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_INDEX = 3'd3;
    localparam logic [2:0] ST_PROBE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [31:0] FIB_LO = lphs_pkg::FIB_MUL[31:0];
    localparam logic [31:0] FIB_HI = lphs_pkg::FIB_MUL[63:32];

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic             mode_reg, mode_next;
    logic [63:0]      key_reg, key_next;
    logic [63:0]      pll_reg, pll_next;
    logic [31:0]      pa_reg, pa_next;
    logic [31:0]      pb_reg, pb_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             zero_reg, zero_next;
    lphs_pkg::rsp_t   res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;
    lphs_pkg::rsp_t   rsp_reg, rsp_next;

    // Slot memory: one write port, one read port with registered data.
    logic [63:0]      slot_mem [SLOTS];
    logic [63:0]      rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [63:0]      mem_wdata;

    logic [31:0]      cross_sum;
    logic [63:0]      hash_full;
    logic [IDX_W-1:0] home_idx;
    logic             out_free;
    logic             at_limit;
    logic             fin;
    lphs_pkg::rsp_t   fin_res;
    logic [CNT_W+lphs_pkg::ENTRY_W-1:0] cnt_ext;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The low 64 bits of key * FIB_MUL are built from three 32 x 32 partial
    // products; the high-by-high product only affects bits at 64 and above.
    assign cross_sum = pa_reg + pb_reg;
    assign hash_full = pll_reg + {cross_sum, 32'd0};
    assign home_idx  = hash_full[lphs_pkg::HASH_SHIFT +: IDX_W];

    // The output register can take a new result when it is empty or being drained.
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign at_limit = (count_reg >= CNT_W'(LIMIT));

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        pll_next       = pll_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        idx_next       = idx_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        zero_next      = zero_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        rd_addr        = idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = key_reg;
        fin            = 1'b0;
        fin_res        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the table once after reset, writing every slot empty.
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (&clr_idx_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next  = req.mode;
                    key_next   = req.key;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                pll_next = 64'(key_reg[31:0]) * 64'(FIB_LO);
                pa_next  = key_reg[31:0] * FIB_HI;
                pb_next  = key_reg[63:32] * FIB_LO;
                if (key_reg == 64'd0)
                begin
                    // Key zero lives in its own flag and never touches the table.
                    fin = 1'b1;
                    if (zero_reg)
                    begin
                        fin_res.hit = 1'b1;
                    end
                    else if (mode_reg == lphs_pkg::MODE_INSERT)
                    begin
                        if (at_limit)
                        begin
                            fin_res.full_res = 1'b1;
                        end
                        else
                        begin
                            zero_next        = 1'b1;
                            count_next       = count_reg + 1'b1;
                            fin_res.inserted = 1'b1;
                        end
                    end
                end
                else
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                // Start the walk at the home slot.
                idx_next   = home_idx;
                rd_addr    = home_idx;
                probe_next = '0;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (rd_data_reg == 64'd0)
                begin
                    fin = 1'b1;
                    if (mode_reg == lphs_pkg::MODE_INSERT)
                    begin
                        if (at_limit)
                        begin
                            fin_res.full_res = 1'b1;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            count_next       = count_reg + 1'b1;
                            fin_res.inserted = 1'b1;
                        end
                    end
                end
                else if (rd_data_reg == key_reg)
                begin
                    fin         = 1'b1;
                    fin_res.hit = 1'b1;
                end
                else if (&probe_reg)
                begin
                    // Every slot was probed without finding an empty one.
                    fin              = 1'b1;
                    fin_res.full_res = (mode_reg == lphs_pkg::MODE_INSERT);
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The reported count is the count after this transaction, cut to its field width.
        cnt_ext             = {{lphs_pkg::ENTRY_W{1'b0}}, count_next};
        fin_res.entry_count = cnt_ext[lphs_pkg::ENTRY_W-1:0];

        // A finished transaction goes straight to the output register when it is
        // free, and otherwise waits in the result holding register.
        if (fin)
        begin
            if (out_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = fin_res;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_next   = fin_res;
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            zero_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            zero_reg      <= zero_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        pll_reg   <= pll_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        idx_reg   <= idx_next;
        probe_reg <= probe_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    // Items are handled one at a time and a write always lands before the next item's first
    // read, with the idle, hash and index states between them, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

`ifndef SYNTHESIS
    // Outside the clearing sweep, the table is only written by an insert during a probe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != ST_CLEAR) |-> (state_reg == ST_PROBE))
    else $error("slot write outside of a probe");

    // The count never passes the load limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIMIT))
    else $error("stored count beyond the load limit");

    // The count only ever steps up by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
    else $error("stored count changed by more than one");

    // A result reports at most one of hit, inserted and full.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ($countones({rsp.hit, rsp.inserted, rsp.full_res}) <= 1))
    else $error("conflicting result flags");

    // No request transaction is taken while the table is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req_ready)
    else $error("request accepted during the clearing sweep");
`endif

endmodule

[verif/tb_linear_probe_hash_set.sv]
// Self-checking testbench for the linear-probing hash set: membership model plus random traffic.
`timescale 1ns / 1ps

module tb_linear_probe_hash_set;

    // The table size matches the default of the block; the index width follows from it.
    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);

    // A new key is refused once the count would reach three quarters of the table.
    // The highest count that still accepts one more key is therefore three quarters minus two.
    localparam int LAST_ROOM = SLOTS * 3 / 4 - 2;

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 64;

    // The timeout is far above any correct run. The clearing pass after reset sweeps every slot,
    // and a single transaction can in the worst case walk the whole table.
    localparam int LIMIT = 2_000_000;

    // One accepted request together with the response it should produce.
    typedef struct packed {
        lphs_pkg::req_t req;
        lphs_pkg::rsp_t rsp;
    } outcome_t;

    // Bit-accurate model of the set. It keeps its own slot memory, the flag for key zero
    // and the entry count, and queues the expected response of every accepted request.
    class set_membership_model;
        logic [63:0] slot_mem [SLOTS];
        bit          zero_held;
        int unsigned held_count;
        logic [63:0] members [$];
        outcome_t    awaited_outcomes [$];
        int unsigned errors;
        int unsigned responses_seen;

        function new();
            foreach (slot_mem[i])
                slot_mem[i] = '0;
            zero_held      = 1'b0;
            held_count     = 0;
            errors         = 0;
            responses_seen = 0;
        endfunction

        function logic [IDX_W-1:0] home_of(logic [63:0] k);
            logic [63:0] prod;
            prod = k * lphs_pkg::FIB_MUL;
            return prod[lphs_pkg::HASH_SHIFT +: IDX_W];
        endfunction

        function bit no_room();
            return (longint'(held_count) + 1) * 4 >= longint'(SLOTS) * 3;
        endfunction

        function int unsigned outstanding();
            return awaited_outcomes.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Applies one request to the model state and queues the response it must give.
        function void note_request(lphs_pkg::req_t r);
            outcome_t         o;
            logic [IDX_W-1:0] idx;
            bit               found_empty;
            bit               asking;

            o.req       = r;
            o.rsp       = '0;
            asking      = (r.mode == lphs_pkg::MODE_QUERY);
            found_empty = 1'b0;

            if (r.key == '0)
            begin
                if (zero_held)
                begin
                    o.rsp.hit = 1'b1;
                end
                else if (!asking)
                begin
                    if (no_room())
                    begin
                        o.rsp.full_res = 1'b1;
                    end
                    else
                    begin
                        zero_held = 1'b1;
                        held_count++;
                        o.rsp.inserted = 1'b1;
                    end
                end
            end
            else
            begin
                idx = home_of(r.key);
                for (int n = 0; n < SLOTS; n++)
                begin
                    if (slot_mem[idx] == '0)
                    begin
                        found_empty = 1'b1;
                        break;
                    end
                    if (slot_mem[idx] == r.key)
                    begin
                        o.rsp.hit = 1'b1;
                        break;
                    end
                    idx = idx + 1'b1;
                end
                if (!o.rsp.hit && !asking)
                begin
                    if (!found_empty || no_room())
                    begin
                        o.rsp.full_res = 1'b1;
                    end
                    else
                    begin
                        slot_mem[idx] = r.key;
                        held_count++;
                        members.push_back(r.key);
                        o.rsp.inserted = 1'b1;
                    end
                end
            end

            o.rsp.entry_count = held_count[lphs_pkg::ENTRY_W-1:0];
            awaited_outcomes.push_back(o);
        endfunction

        // Compares one accepted response with the oldest expectation, field by field.
        task check_response(lphs_pkg::rsp_t got);
            outcome_t o;
            string    tag;

            responses_seen++;
            if (awaited_outcomes.size() == 0)
            begin
                report($sformatf("response %0d arrived with nothing expected", responses_seen));
                return;
            end
            o   = awaited_outcomes.pop_front();
            tag = $sformatf("response %0d (mode %0b key %h)", responses_seen, o.req.mode,
                            o.req.key);
            if (got.hit !== o.rsp.hit)
                report($sformatf("%s hit %b, expected %b", tag, got.hit, o.rsp.hit));
            if (got.inserted !== o.rsp.inserted)
                report($sformatf("%s inserted %b, expected %b", tag, got.inserted,
                                 o.rsp.inserted));
            if (got.full_res !== o.rsp.full_res)
                report($sformatf("%s full_res %b, expected %b", tag, got.full_res,
                                 o.rsp.full_res));
            if (got.entry_count !== o.rsp.entry_count)
                report($sformatf("%s entry_count %0d, expected %0d", tag, got.entry_count,
                                 o.rsp.entry_count));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    lphs_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    lphs_pkg::rsp_t rsp;

    // When set, the sender or the receiver runs back to back without drawing any idle cycles.
    bit tx_burst;
    bit rx_burst;

    set_membership_model model;

    linear_probe_hash_set #(
        .SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Returns a random nonzero key whose home slot is the given one. About one try in
    // SLOTS succeeds, which costs no simulated time.
    function automatic logic [63:0] key_for_slot(logic [IDX_W-1:0] target);
        logic [63:0] k;
        do
        begin
            k = {$urandom, $urandom};
        end
        while (k == '0 || model.home_of(k) != target);
        return k;
    endfunction

    function automatic logic [63:0] random_member();
        return model.members[$urandom_range(0, model.members.size() - 1)];
    endfunction

    // Presents one request and holds it until the block takes it. Valid is only lowered
    // when an idle gap is drawn, so it is never dropped and raised within one time step.
    // The task is entered and left at a rising edge.
    task automatic send_request(input logic m, input logic [63:0] k);
        lphs_pkg::req_t r;
        int unsigned    gap;

        r.mode = m;
        r.key  = k;
        gap    = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        model.note_request(r);
    endtask

    // Holds off the sender until every expected response has been taken. The count is
    // looked at on the falling edge, where the response process has already run.
    task automatic wait_for_quiet();
        req_valid <= 1'b0;
        @(negedge clk);
        while (model.outstanding() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Receiver: after each response it draws a random stall with ready low, none while rx_burst
    // is set, then raises ready and waits for the next transaction.
    initial
    begin
        int unsigned stall;

        rsp_ready = 1'b0;
        rx_burst  = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rsp_valid && rsp_ready));
            model.check_response(rsp);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [63:0] wrap_keys [5];
        logic [63:0] k;
        int unsigned pick;

        model     = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        tx_burst  = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Five keys that all hash to the second-to-last slot. Four of them are stored and
        // form a run that wraps past the end of the table; the fifth is only looked up, so
        // its walk must cross the whole run and the wrap before it meets an empty slot.
        foreach (wrap_keys[i])
            wrap_keys[i] = key_for_slot(IDX_W'(SLOTS - 2));

        // Directed part: key zero and the extreme keys on an empty set, repeated inserts,
        // and lookups that hit and miss.
        send_request(lphs_pkg::MODE_QUERY,  64'h0);
        send_request(lphs_pkg::MODE_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphs_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphs_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphs_pkg::MODE_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphs_pkg::MODE_INSERT, 64'h1);
        send_request(lphs_pkg::MODE_INSERT, 64'h8000_0000_0000_0000);
        send_request(lphs_pkg::MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(lphs_pkg::MODE_INSERT, 64'h5555_5555_5555_5555);
        for (int i = 0; i < 4; i++)
            send_request(lphs_pkg::MODE_INSERT, wrap_keys[i]);
        send_request(lphs_pkg::MODE_QUERY,  wrap_keys[3]);
        send_request(lphs_pkg::MODE_QUERY,  wrap_keys[4]);
        send_request(lphs_pkg::MODE_INSERT, wrap_keys[0]);
        send_request(lphs_pkg::MODE_QUERY,  64'h5555_5555_5555_5555);
        send_request(lphs_pkg::MODE_QUERY,  64'h1);
        send_request(lphs_pkg::MODE_QUERY,  64'h2);
        wait_for_quiet();

        // Random part. Most traffic is new keys, re-inserts and lookups of stored keys, so
        // the set fills up to its load limit well before the end; after that new keys must
        // come back refused while stored keys still hit. Some new keys are aimed at the home
        // slot of a stored key to build long probe runs. Key zero is stored exactly when one
        // free place is left, which checks the boundary of the load limit, and is later
        // re-inserted and queried at the limit.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                tx_burst = !tx_burst;
            if ($urandom_range(0, 99) == 0)
                wait_for_quiet();
            pick = $urandom_range(0, 99);
            if (!model.zero_held && model.held_count == LAST_ROOM)
            begin
                send_request(lphs_pkg::MODE_INSERT, 64'h0);
            end
            else if (pick < 45)
            begin
                if (model.members.size() != 0 && $urandom_range(0, 3) == 0)
                    k = key_for_slot(model.home_of(random_member()));
                else
                    k = {$urandom, $urandom};
                send_request(lphs_pkg::MODE_INSERT, k);
            end
            else if (pick < 65 && model.members.size() != 0)
            begin
                send_request(lphs_pkg::MODE_INSERT, random_member());
            end
            else if (pick < 88 && model.members.size() != 0)
            begin
                send_request(lphs_pkg::MODE_QUERY, random_member());
            end
            else if (pick < 97)
            begin
                if (model.members.size() != 0 && $urandom_range(0, 1) == 0)
                    k = key_for_slot(model.home_of(random_member()));
                else
                    k = {$urandom, $urandom};
                send_request(lphs_pkg::MODE_QUERY, k);
            end
            else
            begin
                // Key zero may only be inserted here once it is already held.
                send_request(model.zero_held ? 1'($urandom_range(0, 1))
                                             : lphs_pkg::MODE_QUERY,
                             64'h0);
            end
        end

        // Let every response come back, then give a stray extra response time to show up.
        wait_for_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (model.outstanding() != 0)
            model.report($sformatf("%0d responses never arrived", model.outstanding()));

        if (model.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
